@@ rtl/core/rotation_matrix_to_quaternion_macros.svh @@
// Assertion macros for the rotation matrix to quaternion block.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef SYNTH
`define RMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq: same-cycle check failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq: next-cycle check failed");
`else
`define RMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/rmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, codes and width helpers shared by the matrix to quaternion files.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int RMQ_FRAC_BITS = 14;
    // Quotient bits kept by the divider chain; the top two flag overflow.
    localparam int RMQ_Q_W       = 17;
    // Width of an off-diagonal sum or difference.
    localparam int RMQ_D_W       = 17;

    localparam logic [1:0] CASE_W = 2'd0;
    localparam logic [1:0] CASE_X = 2'd1;
    localparam logic [1:0] CASE_Y = 2'd2;
    localparam logic [1:0] CASE_Z = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [1:0]         case_taken;
        logic               degenerate;
    } t_quat;

    // Sideband that rides along the square root chain.
    typedef struct packed {
        logic [1:0]                  case_sel;
        logic signed [RMQ_D_W-1:0]   d0;
        logic signed [RMQ_D_W-1:0]   d1;
        logic signed [RMQ_D_W-1:0]   d2;
    } t_sq_side;

    // Sideband that rides along the divider chain.
    typedef struct packed {
        logic [1:0]  case_sel;
        logic [2:0]  neg;
        logic        degen;
        logic [15:0] big;
    } t_dv_side;

    // Unsigned radicand width.
    function automatic int rmq_r_w(input int f);
        return ((f > 17) ? f : 17) + 2;
    endfunction

    // Square root result width.
    function automatic int rmq_sq_w(input int f);
        return (rmq_r_w(f) + f + 1) >> 1;
    endfunction

    // Divider datapath width.
    function automatic int rmq_dv_w(input int f);
        return ((19 + f) > (rmq_sq_w(f) + 18)) ? (19 + f) : (rmq_sq_w(f) + 18);
    endfunction

endpackage

@@ rtl/core/rmq_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One step of a restoring square root: resolves one result bit per cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = RMQ_FRAC_BITS,
    parameter int POS       = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [2*rmq_sq_w(FRAC_BITS)-1:0]      i_n,
    input  logic [2*rmq_sq_w(FRAC_BITS)-1:0]      i_res,
    input  t_sq_side                              i_side,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [2*rmq_sq_w(FRAC_BITS)-1:0]      o_n,
    output logic [2*rmq_sq_w(FRAC_BITS)-1:0]      o_res,
    output t_sq_side                              o_side
);

    localparam int NW = 2 * rmq_sq_w(FRAC_BITS);
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * POS);

    logic            r_valid;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_res;
    t_sq_side        r_side;
    logic [NW-1:0]   n_n;
    logic [NW-1:0]   n_res;
    logic [NW-1:0]   trial;
    logic            fits;

    // Try to subtract the trial value for this bit position.
    always_comb begin
        trial = i_res + BIT;
        fits  = (i_n >= trial);
        n_n   = fits ? (i_n - trial) : i_n;
        n_res = fits ? ((i_res >> 1) + BIT) : (i_res >> 1);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_n    <= n_n;
            r_res  <= n_res;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_res   = r_res;
    assign o_side  = r_side;

endmodule

@@ rtl/core/rmq_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_cell
// One step of a three-lane restoring divider: one quotient bit per lane.
// ----------------------------------------------------------------------------
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = RMQ_FRAC_BITS,
    parameter int POS       = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rmq_dv_w(FRAC_BITS)-1:0]    i_rem [3],
    input  logic [RMQ_Q_W-1:0]                i_q [3],
    input  logic [rmq_dv_w(FRAC_BITS)-1:0]    i_div,
    input  t_dv_side                          i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rmq_dv_w(FRAC_BITS)-1:0]    o_rem [3],
    output logic [RMQ_Q_W-1:0]                o_q [3],
    output logic [rmq_dv_w(FRAC_BITS)-1:0]    o_div,
    output t_dv_side                          o_side
);

    localparam int DW = rmq_dv_w(FRAC_BITS);
    localparam logic [RMQ_Q_W-1:0] QBIT = RMQ_Q_W'(1) << POS;

    logic            r_valid;
    logic [DW-1:0]   r_rem [3];
    logic [RMQ_Q_W-1:0] r_q [3];
    logic [DW-1:0]   r_div;
    t_dv_side        r_side;
    logic [DW-1:0]   n_rem [3];
    logic [RMQ_Q_W-1:0] n_q [3];
    logic [DW-1:0]   shifted;

    // Compare each lane remainder with the divisor at this bit weight.
    always_comb begin
        shifted = i_div << POS;
        for (int l = 0; l < 3; l++) begin
            if (i_rem[l] >= shifted) begin
                n_rem[l] = i_rem[l] - shifted;
                n_q[l]   = i_q[l] | QBIT;
            end else begin
                n_rem[l] = i_rem[l];
                n_q[l]   = i_q[l];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q2.14 rotation matrix to a unit quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
//  channel  | signals                    | payload
//  matrix   | i_valid / o_ready          | i_mat  (nine entries)
//  quat     | o_valid / i_ready          | o_quat (x y z w, case, degenerate)
//
//  One matrix is accepted per cycle while the output is not stalled; the path is
//  two front stages, one square root cell per root bit, two setup stages,
//  17 divider cells and the output register.
//  Every stage holds its beat when the one after it is full and stalled, so
//  bubbles close up and input beats keep flowing while a result waits, until
//  every stage holds a beat.
//  Reset clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = RMQ_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_mat  i_mat,
    output logic  o_valid,
    input  logic  i_ready,
    output t_quat o_quat
);

    localparam int RW  = rmq_r_w(FRAC_BITS);
    localparam int RSW = RW + 1;
    localparam int SQW = rmq_sq_w(FRAC_BITS);
    localparam int NW  = 2 * SQW;
    localparam int DW  = rmq_dv_w(FRAC_BITS);
    localparam int NDC = RMQ_Q_W;
    localparam logic signed [RSW-1:0] ONE = RSW'(1) << FRAC_BITS;

    // ---------------- front stage 1: trace and case ----------------
    logic        r_f1_v;
    t_mat        r_f1_mat;
    logic [1:0]  r_f1_case;
    logic [1:0]  n_f1_case;
    logic signed [17:0] trace;
    logic        f1_rdy;
    logic        f2_rdy;

    always_comb begin
        trace = 18'(i_mat.m00) + 18'(i_mat.m11) + 18'(i_mat.m22);
        if (trace > 18'sd0) begin
            n_f1_case = CASE_W;
        end else if ((i_mat.m00 > i_mat.m11) && (i_mat.m00 > i_mat.m22)) begin
            n_f1_case = CASE_X;
        end else if (i_mat.m11 > i_mat.m22) begin
            n_f1_case = CASE_Y;
        end else begin
            n_f1_case = CASE_Z;
        end
    end

    assign f1_rdy  = !r_f1_v || f2_rdy;
    assign o_ready = f1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (f1_rdy) begin
            r_f1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_rdy && i_valid) begin
            r_f1_mat  <= i_mat;
            r_f1_case <= n_f1_case;
        end
    end

    // ---------------- front stage 2: radicand and off-diagonals ----------------
    logic                r_f2_v;
    logic [NW-1:0]       r_f2_n;
    t_sq_side            r_f2_side;
    logic signed [RSW-1:0] e00, e11, e22, rad;
    logic [NW-1:0]       n_f2_n;
    t_sq_side            n_f2_side;
    logic signed [RMQ_D_W-1:0] d_21m12, d_02m20, d_10m01, d_01p10, d_02p20, d_12p21;

    logic                sq_v   [SQW+1];
    logic                sq_rdy [SQW+1];
    logic [NW-1:0]       sq_n   [SQW+1];
    logic [NW-1:0]       sq_res [SQW+1];
    t_sq_side            sq_side[SQW+1];

    always_comb begin
        e00 = RSW'(r_f1_mat.m00);
        e11 = RSW'(r_f1_mat.m11);
        e22 = RSW'(r_f1_mat.m22);
        d_21m12 = RMQ_D_W'(r_f1_mat.m21) - RMQ_D_W'(r_f1_mat.m12);
        d_02m20 = RMQ_D_W'(r_f1_mat.m02) - RMQ_D_W'(r_f1_mat.m20);
        d_10m01 = RMQ_D_W'(r_f1_mat.m10) - RMQ_D_W'(r_f1_mat.m01);
        d_01p10 = RMQ_D_W'(r_f1_mat.m01) + RMQ_D_W'(r_f1_mat.m10);
        d_02p20 = RMQ_D_W'(r_f1_mat.m02) + RMQ_D_W'(r_f1_mat.m20);
        d_12p21 = RMQ_D_W'(r_f1_mat.m12) + RMQ_D_W'(r_f1_mat.m21);
        n_f2_side.case_sel = r_f1_case;
        unique case (r_f1_case)
            CASE_W: begin
                rad = ONE + e00 + e11 + e22;
                n_f2_side.d0 = d_21m12;
                n_f2_side.d1 = d_02m20;
                n_f2_side.d2 = d_10m01;
            end
            CASE_X: begin
                rad = ONE + e00 - e11 - e22;
                n_f2_side.d0 = d_21m12;
                n_f2_side.d1 = d_01p10;
                n_f2_side.d2 = d_02p20;
            end
            CASE_Y: begin
                rad = ONE + e11 - e00 - e22;
                n_f2_side.d0 = d_02m20;
                n_f2_side.d1 = d_01p10;
                n_f2_side.d2 = d_12p21;
            end
            default: begin
                rad = ONE + e22 - e00 - e11;
                n_f2_side.d0 = d_10m01;
                n_f2_side.d1 = d_02p20;
                n_f2_side.d2 = d_12p21;
            end
        endcase
        // A negative radicand counts as zero.
        if (rad[RSW-1]) begin
            n_f2_n = '0;
        end else begin
            n_f2_n = NW'(rad[RW-1:0]) << FRAC_BITS;
        end
    end

    assign f2_rdy = !r_f2_v || sq_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (f2_rdy) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_rdy && r_f1_v) begin
            r_f2_n    <= n_f2_n;
            r_f2_side <= n_f2_side;
        end
    end

    // ---------------- square root chain ----------------
    assign sq_v[0]    = r_f2_v;
    assign sq_n[0]    = r_f2_n;
    assign sq_res[0]  = '0;
    assign sq_side[0] = r_f2_side;

    for (genvar k = 0; k < SQW; k++) begin : g_sqrt
        rmq_sqrt_cell #(
            .FRAC_BITS (FRAC_BITS),
            .POS       (SQW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_rdy[k]),
            .i_n     (sq_n[k]),
            .i_res   (sq_res[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_n     (sq_n[k+1]),
            .o_res   (sq_res[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // ---------------- setup stage G: round the root ----------------
    logic            r_g_v;
    logic [SQW:0]    r_g_root;
    t_sq_side        r_g_side;
    logic            g_rdy;
    logic            h_rdy;

    assign g_rdy       = !r_g_v || h_rdy;
    assign sq_rdy[SQW] = g_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (g_rdy) begin
            r_g_v <= sq_v[SQW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_rdy && sq_v[SQW]) begin
            r_g_root <= (SQW+1)'(sq_res[SQW][SQW-1:0])
                      + (SQW+1)'(sq_n[SQW] > sq_res[SQW]);
            r_g_side <= sq_side[SQW];
        end
    end

    // ---------------- setup stage H: dividends, divisor, root component ----------------
    logic               dv_v   [NDC+1];
    logic               dv_rdy [NDC+1];
    logic [DW-1:0]      dv_rem [NDC+1][3];
    logic [RMQ_Q_W-1:0] dv_q   [NDC+1][3];
    logic [DW-1:0]      dv_div [NDC+1];
    t_dv_side           dv_side[NDC+1];

    logic               r_h_v;
    logic [DW-1:0]      r_h_num [3];
    logic [DW-1:0]      r_h_div;
    t_dv_side           r_h_side;
    logic [DW-1:0]      n_h_num [3];
    t_dv_side           n_h_side;
    logic [SQW:0]       big;
    logic signed [RMQ_D_W-1:0] dsel [3];
    logic [RMQ_D_W-1:0] mag  [3];

    always_comb begin
        dsel[0] = r_g_side.d0;
        dsel[1] = r_g_side.d1;
        dsel[2] = r_g_side.d2;
        for (int l = 0; l < 3; l++) begin
            n_h_side.neg[l] = dsel[l][RMQ_D_W-1];
            mag[l]          = dsel[l][RMQ_D_W-1] ? RMQ_D_W'(-dsel[l]) : RMQ_D_W'(dsel[l]);
            n_h_num[l]      = (DW'(mag[l]) << FRAC_BITS) + DW'(r_g_root);
        end
        big               = (r_g_root + (SQW+1)'(1)) >> 1;
        n_h_side.case_sel = r_g_side.case_sel;
        n_h_side.degen    = (r_g_root == '0);
        n_h_side.big      = (big > (SQW+1)'(32767)) ? 16'h7fff : big[15:0];
    end

    assign h_rdy = !r_h_v || dv_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (h_rdy) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_rdy && r_g_v) begin
            r_h_num  <= n_h_num;
            r_h_div  <= DW'(r_g_root) << 1;
            r_h_side <= n_h_side;
        end
    end

    // ---------------- divider chain ----------------
    assign dv_v[0]    = r_h_v;
    assign dv_rem[0]  = r_h_num;
    assign dv_div[0]  = r_h_div;
    assign dv_side[0] = r_h_side;
    assign dv_q[0][0] = '0;
    assign dv_q[0][1] = '0;
    assign dv_q[0][2] = '0;

    for (genvar k = 0; k < NDC; k++) begin : g_div
        rmq_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .POS       (NDC - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .o_ready (dv_rdy[k]),
            .i_rem   (dv_rem[k]),
            .i_q     (dv_q[k]),
            .i_div   (dv_div[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_v[k+1]),
            .i_ready (dv_rdy[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_q     (dv_q[k+1]),
            .o_div   (dv_div[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // ---------------- output stage: sign, saturation, placement ----------------
    logic        r_o_v;
    t_quat       r_o_quat;
    t_quat       n_o_quat;
    logic        o_rdy;
    logic [15:0] lane [3];
    t_dv_side    fin;

    always_comb begin
        fin = dv_side[NDC];
        for (int l = 0; l < 3; l++) begin
            if (dv_q[NDC][l][16] || dv_q[NDC][l][15]) begin
                lane[l] = fin.neg[l] ? 16'h8000 : 16'h7fff;
            end else begin
                lane[l] = fin.neg[l] ? (16'h0000 - {1'b0, dv_q[NDC][l][14:0]})
                                     : {1'b0, dv_q[NDC][l][14:0]};
            end
        end
        n_o_quat.case_taken = fin.case_sel;
        n_o_quat.degenerate = fin.degen;
        unique case (fin.case_sel)
            CASE_W: begin
                n_o_quat.quat_w = fin.big;
                n_o_quat.quat_x = lane[0];
                n_o_quat.quat_y = lane[1];
                n_o_quat.quat_z = lane[2];
            end
            CASE_X: begin
                n_o_quat.quat_x = fin.big;
                n_o_quat.quat_w = lane[0];
                n_o_quat.quat_y = lane[1];
                n_o_quat.quat_z = lane[2];
            end
            CASE_Y: begin
                n_o_quat.quat_y = fin.big;
                n_o_quat.quat_w = lane[0];
                n_o_quat.quat_x = lane[1];
                n_o_quat.quat_z = lane[2];
            end
            default: begin
                n_o_quat.quat_z = fin.big;
                n_o_quat.quat_w = lane[0];
                n_o_quat.quat_x = lane[1];
                n_o_quat.quat_y = lane[2];
            end
        endcase
        // A zero divisor forces the quaternion to zero.
        if (fin.degen) begin
            n_o_quat.quat_x = '0;
            n_o_quat.quat_y = '0;
            n_o_quat.quat_z = '0;
            n_o_quat.quat_w = '0;
        end
    end

    assign o_rdy       = !r_o_v || i_ready;
    assign dv_rdy[NDC] = o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_rdy) begin
            r_o_v <= dv_v[NDC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && dv_v[NDC]) begin
            r_o_quat <= n_o_quat;
        end
    end

    assign o_valid = r_o_v;
    assign o_quat  = r_o_quat;

    // ---------------- assertions ----------------
    logic quat_zero;
    logic out_w_case;
    logic all_empty;

    assign quat_zero  = (o_quat.quat_x == '0) && (o_quat.quat_y == '0)
                     && (o_quat.quat_z == '0) && (o_quat.quat_w == '0);
    assign out_w_case = o_valid && (o_quat.case_taken == CASE_W);
    assign all_empty  = !r_o_v && !r_h_v && !r_g_v && !r_f2_v && !r_f1_v;

    `RMQ_ASSERT_SAME(a_degen_zero, i_clk, i_rst_n, o_valid && o_quat.degenerate, quat_zero)
    `RMQ_ASSERT_SAME(a_root_nonneg, i_clk, i_rst_n, out_w_case, !o_quat.quat_w[15])
    `RMQ_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n, all_empty, o_ready)
    `RMQ_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, o_rdy && dv_v[NDC], o_valid)

endmodule
